### sv/bfth_pkg.sv
`timescale 1ns / 1ps

package bfth_pkg;

    // default bit table size, must be a power of two
    localparam int unsigned TABLE_ENTRIES_DEF = 4096;

    localparam int unsigned CH_W = 7;

    // hash start values before masking to the table index width
    localparam logic [31:0] SHIFT_SEED = 32'd32;
    localparam logic [31:0] XOR_SEED   = 32'd1315423911;

    // command carried on the input tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic            absorb;   // fold ch into all three hashes
        logic            restart;  // return hashes to their start values
        logic [CH_W-1:0] ch;
    } t_hash_ctl;

endpackage

### sv/bfth_ram.sv
`timescale 1ns / 1ps

module bfth_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/bfth_hash.sv
`timescale 1ns / 1ps

module bfth_hash
    import bfth_pkg::*;
#(
    parameter int unsigned IDX_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_hash_ctl        i_ctl,
    output logic [IDX_W-1:0] o_idx_shift,
    output logic [IDX_W-1:0] o_idx_xor,
    output logic [IDX_W-1:0] o_idx_sdbm
);

    localparam int unsigned XW = IDX_W + CH_W;

    logic [IDX_W-1:0] r_shift, n_shift;
    logic [IDX_W-1:0] r_power, n_power;
    logic [IDX_W-1:0] r_xor, n_xor;
    logic [IDX_W-1:0] r_sdbm, n_sdbm;

    logic [XW-1:0] w_ch;
    logic [XW-1:0] w_prod;
    logic [XW-1:0] w_xmix;
    logic [XW-1:0] w_sdbm;

    assign w_ch   = {{IDX_W{1'b0}}, i_ctl.ch};
    // 7 x IDX_W product, low bits are all that survive the mask
    assign w_prod = w_ch * {{CH_W{1'b0}}, r_power};
    assign w_xmix = ({{CH_W{1'b0}}, r_xor} << 5) + w_ch + ({{CH_W{1'b0}}, r_xor} >> 2);
    assign w_sdbm = w_ch + ({{CH_W{1'b0}}, r_sdbm} << 6) + ({{CH_W{1'b0}}, r_sdbm} << 16)
                    - {{CH_W{1'b0}}, r_sdbm};

    always_comb begin
        n_shift = r_shift;
        n_power = r_power;
        n_xor   = r_xor;
        n_sdbm  = r_sdbm;
        if (i_ctl.restart) begin
            n_shift = '0;
            n_power = SHIFT_SEED[IDX_W-1:0];
            n_xor   = XOR_SEED[IDX_W-1:0];
            n_sdbm  = '0;
        end else if (i_ctl.absorb) begin
            n_shift = r_shift + w_prod[IDX_W-1:0];
            n_power = r_power << 5;
            n_xor   = r_xor ^ w_xmix[IDX_W-1:0];
            n_sdbm  = w_sdbm[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_power <= SHIFT_SEED[IDX_W-1:0];
            r_xor   <= XOR_SEED[IDX_W-1:0];
            r_sdbm  <= '0;
        end else begin
            r_shift <= n_shift;
            r_power <= n_power;
            r_xor   <= n_xor;
            r_sdbm  <= n_sdbm;
        end
    end

    assign o_idx_shift = r_shift;
    assign o_idx_xor   = r_xor;
    assign o_idx_sdbm  = r_sdbm;

endmodule

### sv/bloom_filter_three_hash_unit.sv
`timescale 1ns / 1ps

// Three-hash Bloom filter over a TABLE_ENTRIES x 1 bit table.
// Slave stream: one key character per transaction. tdata = {has_char, ch},
// tuser = command (insert / query), tlast ends the key. Master stream: one
// transaction per query key, tdata bit 0 = found; inserts give no transaction.
// Throughput: a non-final transaction is taken every cycle while idle, the
// three hashes update from registered state. A final transaction then does
// three accesses to the bit table, one per hash index: an insert keeps the
// slave side busy for its three writes, a query for its three reads, the
// registered read data of the last one, then loading the output register.
// Reset: the synchronous reset starts a clearing pass that writes zero to
// every table entry, one per cycle; tready stays low until it ends. Hashes
// reset to their start values.
// Stall: the result waits in the output register; further characters are
// still taken, and the next query only completes once the held result is
// taken by the receiver.
module bloom_filter_three_hash_unit
    import bfth_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [6:0] ch, [7] has_char
    input  logic       i_s_tuser,   // [0] cmd
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] found, [7:1] zero
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_ACCESS = 2'd2;
    localparam logic [1:0] ST_FIN    = 2'd3;

    localparam logic [1:0] STEP_SHIFT = 2'd0;
    localparam logic [1:0] STEP_XOR   = 2'd1;
    localparam logic [1:0] STEP_SDBM  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_step, n_step;
    logic [IDX_W-1:0] r_clr_addr;
    logic             r_cmd;
    logic             r_hit;
    logic             r_rd_pending;
    logic             r_out_valid;
    logic             r_found;

    logic             w_accept;
    logic             w_accept_last;
    logic             w_out_take;
    logic             w_load_out;
    logic             w_access_end;
    t_hash_ctl        w_hash_ctl;
    logic [IDX_W-1:0] w_idx_shift, w_idx_xor, w_idx_sdbm;
    logic [IDX_W-1:0] w_sel_addr;
    logic             w_we, w_wdata, w_re, w_rdata;
    logic [IDX_W-1:0] w_waddr;

    assign o_s_tready    = (r_state == ST_IDLE);
    assign w_accept      = i_s_tvalid && o_s_tready;
    assign w_accept_last = w_accept && i_s_tlast;
    assign w_out_take    = r_out_valid && i_m_tready;
    assign w_access_end  = (r_state == ST_ACCESS) && (r_step == STEP_SDBM);
    // last read has landed and the output register is free
    assign w_load_out    = (r_state == ST_FIN) && !r_rd_pending
                           && (!r_out_valid || i_m_tready);

    // hashes hold until the third access is issued, then restart
    assign w_hash_ctl.absorb  = w_accept && i_s_tdata[7];
    assign w_hash_ctl.restart = w_access_end;
    assign w_hash_ctl.ch      = i_s_tdata[CH_W-1:0];

    bfth_hash #(
        .IDX_W(IDX_W)
    ) u_hash (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_hash_ctl),
        .o_idx_shift (w_idx_shift),
        .o_idx_xor   (w_idx_xor),
        .o_idx_sdbm  (w_idx_sdbm)
    );

    always_comb begin
        unique case (r_step)
            STEP_SHIFT: w_sel_addr = w_idx_shift;
            STEP_XOR:   w_sel_addr = w_idx_xor;
            default:    w_sel_addr = w_idx_sdbm;
        endcase
    end

    assign w_we    = (r_state == ST_CLEAR) || ((r_state == ST_ACCESS) && (r_cmd == CMD_INSERT));
    assign w_wdata = (r_state != ST_CLEAR);
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr_addr : w_sel_addr;
    assign w_re    = (r_state == ST_ACCESS) && (r_cmd == CMD_QUERY);

    bfth_ram #(
        .WIDTH(1),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_sel_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_CLEAR: begin
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept_last) begin
                    n_state = ST_ACCESS;
                    n_step  = STEP_SHIFT;
                end
            end
            ST_ACCESS: begin
                n_step = r_step + 2'd1;
                if (w_access_end) begin
                    n_state = (r_cmd == CMD_QUERY) ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_step       <= STEP_SHIFT;
            r_clr_addr   <= '0;
            r_rd_pending <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_rd_pending <= w_re;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: command of the final transaction, AND of the three table bits
    always_ff @(posedge i_clk) begin
        if (w_accept_last) begin
            r_cmd <= i_s_tuser;
            r_hit <= 1'b1;
        end else if (r_rd_pending) begin
            r_hit <= r_hit & w_rdata;
        end
        if (w_load_out) begin
            r_found <= r_hit;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_found};

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACCESS) |-> (r_step != 2'd3))
        else $error("access step out of range");

    a_read_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pending |-> $past((r_state == ST_ACCESS) && (r_cmd == CMD_QUERY)))
        else $error("table read outside a query access");

    a_result_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past((r_state == ST_FIN) && (r_cmd == CMD_QUERY)))
        else $error("result produced without a query");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!o_s_tready && !o_m_tvalid))
        else $error("channel active during clearing pass");

endmodule
